@@ hw/rtl/psve_pkg.sv @@
// ----------------------------------------------------------------------------
// psve_pkg
// Shared types, constants and table builders for the sine voice engine.
// ----------------------------------------------------------------------------
`default_nettype none

package psve_pkg;

   // Engine geometry
   localparam int VOICE_COUNT  = 16;
   localparam int VOICE_BITS   = 4;
   localparam int AUDIO_RATE   = 44100;
   localparam int SINE_ENTRIES = 1024;
   localparam int SINE_BITS    = 10;
   localparam int PHASE_BITS   = 24;

   // Fixed-point limits
   localparam logic [19:0] AGE_MAX     = 20'hFFFFF;
   localparam logic [16:0] ENV_ONE     = 17'd32768;
   localparam int          CLAMP_LEVEL = 31129;
   // ceil(2^31 / 127): x / 127 == (x * LEVEL_RECIP) >> 31 for x < 2^23
   localparam logic [24:0] LEVEL_RECIP = 25'd16909321;

   // Item kinds
   localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
   localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
   localparam logic [1:0] KIND_TICK     = 2'd2;
   localparam logic [1:0] KIND_IGNORED  = 2'd3;

   // Register indexes
   localparam logic [2:0] REG_MASTER_VOLUME  = 3'd0;
   localparam logic [2:0] REG_ATTACK_LENGTH  = 3'd1;
   localparam logic [2:0] REG_DECAY_LENGTH   = 3'd2;
   localparam logic [2:0] REG_RELEASE_LENGTH = 3'd3;
   localparam logic [2:0] REG_SUSTAIN_LEVEL  = 3'd4;

   typedef logic signed [15:0] sine_table_type [SINE_ENTRIES];
   typedef logic [PHASE_BITS-1:0] incr_table_type [128];

   // Controller to datapath commands
   typedef struct packed {
      logic                  load_req;
      logic                  start_free;
      logic                  scan_init;
      logic                  scan_step;
      logic                  start_chosen;
      logic                  release_voice;
      logic                  tick_load;
      logic                  env_eval;
      logic                  env_capture;
      logic                  mul1;
      logic                  mul2;
      logic                  scale_start;
      logic                  mix_acc;
      logic                  final_mul;
      logic                  out_load;
      logic [VOICE_BITS-1:0] vidx;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [1:0] kind;
      logic       free_any;
      logic       chosen_valid;
      logic       vox_active;
      logic       note_match;
      logic       env_div;
      logic       div_done;
      logic       out_full;
   } status_type;

   localparam logic [16:0] SEMITONE_Q16 [12] = '{
      17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
      17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
   };

   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint unsigned TAYLOR_DIV [7] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
   };

   // Sine table, Q1.15, integer Taylor series in Q30
   function automatic sine_table_type build_sine();
      sine_table_type  tbl;
      longint unsigned t, q, r, x, x2, term;
      longint          s, v;
      for (int i = 0; i < SINE_ENTRIES; i++) begin
         t = 64'(4 * i);
         q = t / SINE_ENTRIES;
         r = t % SINE_ENTRIES;
         if (q[0]) r = 64'(SINE_ENTRIES) - r;
         x = (PI_Q30 * r) / (2 * SINE_ENTRIES);
         x2 = (x * x) >> 30;
         term = x;
         s = longint'(x);
         for (int k = 1; k <= 7; k++) begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[k-1];
            if (k % 2 == 1) s = s - longint'(term);
            else s = s + longint'(term);
         end
         if (s < 0) s = 0;
         v = (s * 32767 + (longint'(1) <<< 29)) >>> 30;
         if (v > 32767) v = 32767;
         tbl[i] = (q >= 2) ? 16'(-v) : 16'(v);
      end
      return tbl;
   endfunction

   // Phase increment per MIDI note
   function automatic incr_table_type build_incr();
      incr_table_type  tbl;
      longint unsigned num, numer;
      int              m;
      for (int n = 0; n < 128; n++) begin
         m = n + 3;
         num = (64'd440 * 64'(SEMITONE_Q16[m % 12])) << (m / 12);
         numer = num << (PHASE_BITS - 22);
         tbl[n] = PHASE_BITS'((numer + AUDIO_RATE / 2) / AUDIO_RATE);
      end
      return tbl;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/psve_div.sv @@
// ----------------------------------------------------------------------------
// psve_div
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// The caller guarantees numer / divisor < 2^16.
// ----------------------------------------------------------------------------
`default_nettype none

module psve_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [35:0] numer,
   input  wire logic [19:0] divisor,
   output logic             done,
   output logic [15:0]      quot
);

   logic [19:0] rem_ff, rem_in;
   logic [15:0] low_ff, quot_ff;
   logic [19:0] div_ff;
   logic [3:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [20:0] trial;
   logic        ge;

   // One restoring step
   always_comb begin
      trial  = {rem_ff, low_ff[15]};
      ge     = trial >= {1'b0, div_ff};
      rem_in = ge ? 20'(trial - {1'b0, div_ff}) : trial[19:0];
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= numer[35:16];
         low_ff  <= numer[15:0];
         div_ff  <= divisor;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         low_ff  <= {low_ff[14:0], 1'b0};
         quot_ff <= {quot_ff[14:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

@@ hw/rtl/psve_datapath.sv @@
// ----------------------------------------------------------------------------
// psve_datapath
// Voice state, configuration registers, sine ROM, envelope and mix math.
// ----------------------------------------------------------------------------
`default_nettype none

module psve_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire psve_pkg::cmd_type    cmd,
   output psve_pkg::status_type      status,
   input  wire logic [1:0]           req_kind,
   input  wire logic [6:0]           req_note,
   input  wire logic [6:0]           req_velocity,
   input  wire logic                 csr_write,
   input  wire logic [2:0]           csr_index,
   input  wire logic [19:0]          csr_data,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic signed [15:0]        rsp_sample,
   output logic [4:0]                rsp_active_voices
);

   localparam int NV = psve_pkg::VOICE_COUNT;
   localparam int PB = psve_pkg::PHASE_BITS;

   localparam psve_pkg::sine_table_type SINE_ROM = psve_pkg::build_sine();
   localparam psve_pkg::incr_table_type INCR_ROM = psve_pkg::build_incr();

   // Envelope segment codes
   localparam logic [2:0] ENV_ATTACK  = 3'd0;
   localparam logic [2:0] ENV_DECAY   = 3'd1;
   localparam logic [2:0] ENV_SUSTAIN = 3'd2;
   localparam logic [2:0] ENV_RELEASE = 3'd3;
   localparam logic [2:0] ENV_DONE    = 3'd4;

   // Configuration
   logic [14:0] volume_ff, sustain_ff;
   logic [19:0] attack_ff, decay_ff, release_ff;

   // Voice bank
   logic [NV-1:0] active_ff;
   logic [NV-1:0] released_ff;
   logic [6:0]    note_ff   [NV];
   logic [6:0]    level_ff  [NV];
   logic [PB-1:0] phase_ff  [NV];
   logic [19:0]   age_ff    [NV];
   logic [19:0]   rstart_ff [NV];

   // Latched request and work registers
   logic [1:0]              kind_ff;
   logic [6:0]              rnote_ff, rvel_ff;
   logic [19:0]             oldest_ff;
   logic [psve_pkg::VOICE_BITS-1:0] chosen_ff;
   logic                    chosen_valid_ff;
   logic [19:0]             agew_ff;
   logic signed [15:0]      sine_ff;
   logic [16:0]             env_ff;
   logic                    is_decay_ff;
   logic signed [33:0]      p1_ff;
   logic signed [41:0]      p2_ff;
   logic                    neg_ff;
   logic [15:0]             scale_q_ff;
   logic signed [20:0]      mix_ff;
   logic [4:0]              cnt_ff;
   logic signed [36:0]      prod_ff;
   logic                    rsp_valid_ff;
   logic signed [15:0]      rsp_sample_ff;
   logic [4:0]              rsp_count_ff;

   // Lowest free voice
   logic                            free_any;
   logic [psve_pkg::VOICE_BITS-1:0] free_idx;
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int v = NV - 1; v >= 0; v--) begin
         if (!active_ff[v]) begin
            free_any = 1'b1;
            free_idx = psve_pkg::VOICE_BITS'(v);
         end
      end
   end

   // Envelope segment of the current voice
   logic [2:0]  env_seg;
   logic [20:0] ad_sum;
   logic [19:0] rel_age;
   logic        env_div;
   always_comb begin
      ad_sum  = {1'b0, attack_ff} + {1'b0, decay_ff};
      rel_age = agew_ff - rstart_ff[cmd.vidx];
      if (agew_ff < attack_ff) env_seg = ENV_ATTACK;
      else if ({1'b0, agew_ff} < ad_sum) env_seg = ENV_DECAY;
      else if (!released_ff[cmd.vidx]) env_seg = ENV_SUSTAIN;
      else if (rel_age < release_ff) env_seg = ENV_RELEASE;
      else env_seg = ENV_DONE;
      env_div = env_seg == ENV_ATTACK || env_seg == ENV_DECAY || env_seg == ENV_RELEASE;
   end

   // Divider operands for the envelope ramps
   logic        div_start, div_done;
   logic [35:0] div_numer;
   logic [19:0] div_divisor;
   logic [15:0] div_quot;
   logic [16:0] env_gap;
   logic [19:0] dec_age, rel_left;
   always_comb begin
      env_gap     = psve_pkg::ENV_ONE - {2'b0, sustain_ff};
      dec_age     = agew_ff - attack_ff;
      rel_left    = release_ff - rel_age;
      div_numer   = '0;
      div_divisor = '0;
      case (env_seg)
         ENV_ATTACK: begin
            div_numer   = {1'b0, agew_ff, 15'd0};
            div_divisor = attack_ff;
         end
         ENV_DECAY: begin
            div_numer   = {19'd0, env_gap} * {16'd0, dec_age};
            div_divisor = decay_ff;
         end
         default: begin
            div_numer   = {21'd0, sustain_ff} * {16'd0, rel_left};
            div_divisor = release_ff;
         end
      endcase
      div_start = cmd.env_eval && env_div;
   end

   psve_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .numer   (div_numer),
      .divisor (div_divisor),
      .done    (div_done),
      .quot    (div_quot)
   );

   // Velocity scale: |p2| / 32768 / 127 by reciprocal multiply
   logic [41:0] p2_mag;
   logic [22:0] scale_in;
   logic [47:0] scale_prod;
   always_comb begin
      p2_mag     = p2_ff[41] ? 42'(-p2_ff) : 42'(p2_ff);
      scale_in   = p2_mag[37:15];
      scale_prod = {25'd0, scale_in} * {23'd0, psve_pkg::LEVEL_RECIP};
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff  <= 15'd26214;
         attack_ff  <= 20'd4410;
         decay_ff   <= 20'd8820;
         release_ff <= 20'd22050;
         sustain_ff <= 15'd22938;
      end else if (csr_write) begin
         unique case (csr_index)
            psve_pkg::REG_MASTER_VOLUME:  volume_ff  <= csr_data[14:0];
            psve_pkg::REG_ATTACK_LENGTH:  attack_ff  <= csr_data;
            psve_pkg::REG_DECAY_LENGTH:   decay_ff   <= csr_data;
            psve_pkg::REG_RELEASE_LENGTH: release_ff <= csr_data;
            psve_pkg::REG_SUSTAIN_LEVEL:  sustain_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // Voice active bits
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (cmd.start_free) begin
         active_ff[free_idx] <= 1'b1;
      end else if (cmd.env_eval && env_seg == ENV_DONE) begin
         active_ff[cmd.vidx] <= 1'b0;
      end
   end

   // Voice payload
   always_ff @(posedge clock) begin
      if (cmd.start_free || cmd.start_chosen) begin
         note_ff[cmd.start_free ? free_idx : chosen_ff]     <= rnote_ff;
         level_ff[cmd.start_free ? free_idx : chosen_ff]    <= rvel_ff;
         phase_ff[cmd.start_free ? free_idx : chosen_ff]    <= '0;
         age_ff[cmd.start_free ? free_idx : chosen_ff]      <= '0;
         rstart_ff[cmd.start_free ? free_idx : chosen_ff]   <= '0;
         released_ff[cmd.start_free ? free_idx : chosen_ff] <= 1'b0;
      end
      if (cmd.release_voice) begin
         released_ff[cmd.vidx] <= 1'b1;
         rstart_ff[cmd.vidx]   <= age_ff[cmd.vidx];
      end
      if (cmd.tick_load) begin
         age_ff[cmd.vidx]   <= (age_ff[cmd.vidx] == psve_pkg::AGE_MAX) ?
                               age_ff[cmd.vidx] : age_ff[cmd.vidx] + 20'd1;
         phase_ff[cmd.vidx] <= phase_ff[cmd.vidx] + INCR_ROM[note_ff[cmd.vidx]];
      end
   end

   // Request latch, steal search and per-voice arithmetic
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff  <= req_kind;
         rnote_ff <= req_note;
         rvel_ff  <= req_velocity;
         mix_ff   <= '0;
         cnt_ff   <= '0;
      end
      if (cmd.scan_init) begin
         oldest_ff       <= '0;
         chosen_ff       <= '0;
         chosen_valid_ff <= 1'b0;
      end else if (cmd.scan_step && age_ff[cmd.vidx] > oldest_ff) begin
         oldest_ff       <= age_ff[cmd.vidx];
         chosen_ff       <= cmd.vidx;
         chosen_valid_ff <= 1'b1;
      end
      if (cmd.tick_load) begin
         agew_ff <= (age_ff[cmd.vidx] == psve_pkg::AGE_MAX) ?
                    age_ff[cmd.vidx] : age_ff[cmd.vidx] + 20'd1;
         sine_ff <= SINE_ROM[phase_ff[cmd.vidx][PB-1 -: psve_pkg::SINE_BITS]];
      end
      if (cmd.env_eval) begin
         is_decay_ff <= env_seg == ENV_DECAY;
         if (env_seg == ENV_SUSTAIN) env_ff <= {2'b0, sustain_ff};
         else env_ff <= '0;
      end
      if (cmd.env_capture) begin
         env_ff <= is_decay_ff ? 17'(psve_pkg::ENV_ONE - {1'b0, div_quot})
                               : {1'b0, div_quot};
      end
      if (cmd.mul1) p1_ff <= 34'(sine_ff) * $signed({17'd0, env_ff});
      if (cmd.mul2) p2_ff <= 42'(p1_ff) * $signed({35'd0, level_ff[cmd.vidx]});
      if (cmd.scale_start) begin
         neg_ff     <= p2_ff[41];
         scale_q_ff <= scale_prod[46:31];
      end
      if (cmd.mix_acc) begin
         mix_ff <= neg_ff ? mix_ff - $signed({5'd0, scale_q_ff})
                          : mix_ff + $signed({5'd0, scale_q_ff});
         cnt_ff <= cnt_ff + {4'd0, active_ff[cmd.vidx]};
      end
      if (cmd.final_mul) prod_ff <= 37'(mix_ff) * $signed({22'd0, volume_ff});
   end

   // Volume scaling toward zero and clamp
   logic signed [21:0] scaled;
   logic signed [15:0] clamped;
   always_comb begin
      scaled = prod_ff[36] ? 22'((prod_ff + 37'sd32767) >>> 15) : 22'(prod_ff >>> 15);
      if (scaled > 22'sd31129) clamped = 16'sd31129;
      else if (scaled < -22'sd31129) clamped = -16'sd31129;
      else clamped = scaled[15:0];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_sample_ff <= clamped;
         rsp_count_ff  <= cnt_ff;
      end
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_sample        = rsp_sample_ff;
   assign rsp_active_voices = rsp_count_ff;

   // Status
   always_comb begin
      status.kind         = kind_ff;
      status.free_any     = free_any;
      status.chosen_valid = chosen_valid_ff;
      status.vox_active   = active_ff[cmd.vidx];
      status.note_match   = active_ff[cmd.vidx] && note_ff[cmd.vidx] == rnote_ff;
      status.env_div      = env_div;
      status.div_done     = div_done;
      status.out_full     = rsp_valid_ff && !rsp_tready;
   end

endmodule

`default_nettype wire

@@ hw/rtl/psve_ctrl.sv @@
// ----------------------------------------------------------------------------
// psve_ctrl
// Sequencer for note-on, note-off and tick transactions over the voice bank.
// ----------------------------------------------------------------------------
`default_nettype none

module psve_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_accept,
   output logic                      req_ready,
   output psve_pkg::cmd_type         cmd,
   input  wire psve_pkg::status_type status
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DECODE = 4'd1;
   localparam logic [3:0] ST_ONSCAN = 4'd2;
   localparam logic [3:0] ST_ONPICK = 4'd3;
   localparam logic [3:0] ST_OFF    = 4'd4;
   localparam logic [3:0] ST_LOAD   = 4'd5;
   localparam logic [3:0] ST_ENV    = 4'd6;
   localparam logic [3:0] ST_ENVW   = 4'd7;
   localparam logic [3:0] ST_MUL1   = 4'd8;
   localparam logic [3:0] ST_MUL2   = 4'd9;
   localparam logic [3:0] ST_SCALE  = 4'd10;
   localparam logic [3:0] ST_SCW    = 4'd11;
   localparam logic [3:0] ST_NEXT   = 4'd12;
   localparam logic [3:0] ST_FINAL  = 4'd13;
   localparam logic [3:0] ST_OUT    = 4'd14;

   localparam logic [psve_pkg::VOICE_BITS-1:0] LAST_VOICE =
      psve_pkg::VOICE_BITS'(psve_pkg::VOICE_COUNT - 1);

   logic [3:0]                      state_ff, state_in;
   logic [psve_pkg::VOICE_BITS-1:0] vidx_ff, vidx_in;
   logic                            last;

   always_comb begin
      state_in = state_ff;
      vidx_in  = vidx_ff;
      last     = vidx_ff == LAST_VOICE;
      cmd      = '0;
      cmd.vidx = vidx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            vidx_in = '0;
            unique case (status.kind)
               psve_pkg::KIND_NOTE_ON: begin
                  if (status.free_any) begin
                     cmd.start_free = 1'b1;
                     state_in       = ST_IDLE;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = ST_ONSCAN;
                  end
               end
               psve_pkg::KIND_NOTE_OFF: state_in = ST_OFF;
               psve_pkg::KIND_TICK:     state_in = ST_LOAD;
               default:                 state_in = ST_IDLE;
            endcase
         end
         ST_ONSCAN: begin
            cmd.scan_step = 1'b1;
            vidx_in       = vidx_ff + 1'b1;
            if (last) state_in = ST_ONPICK;
         end
         ST_ONPICK: begin
            cmd.start_chosen = status.chosen_valid;
            state_in         = ST_IDLE;
         end
         ST_OFF: begin
            vidx_in = vidx_ff + 1'b1;
            if (status.note_match) begin
               cmd.release_voice = 1'b1;
               state_in          = ST_IDLE;
            end else if (last) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            if (status.vox_active) begin
               cmd.tick_load = 1'b1;
               state_in      = ST_ENV;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_ENV: begin
            cmd.env_eval = 1'b1;
            state_in     = status.env_div ? ST_ENVW : ST_MUL1;
         end
         ST_ENVW: begin
            if (status.div_done) begin
               cmd.env_capture = 1'b1;
               state_in        = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale_start = 1'b1;
            state_in        = ST_SCW;
         end
         ST_SCW: begin
            cmd.mix_acc = 1'b1;
            state_in    = ST_NEXT;
         end
         ST_NEXT: begin
            vidx_in  = vidx_ff + 1'b1;
            state_in = last ? ST_FINAL : ST_LOAD;
         end
         ST_FINAL: begin
            cmd.final_mul = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (!status.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         vidx_ff  <= vidx_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;

endmodule

`default_nettype wire

@@ hw/rtl/polyphonic_sine_voice_engine.sv @@
// ----------------------------------------------------------------------------
// polyphonic_sine_voice_engine
// Sixteen-voice sine synthesizer with linear ADSR envelope and voice stealing.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A note-on takes the lowest free voice,
// or scans ages to steal the oldest one when none is free. A note-off scans
// the voices in turn and releases the first active one with a matching note.
// A tick walks all sixteen voices in turn: an idle voice is skipped, and an
// active one whose envelope is in attack, decay or release waits for its
// envelope ramp on a shared serial divider; the velocity scale is a
// reciprocal multiply. The mixed sample then waits in an output register that
// frees the input side once loaded.
`default_nettype none

module polyphonic_sine_voice_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [6:0] note, [13:7] velocity
   input  wire logic [1:0]  req_tuser,  // [1:0] kind
   // Results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // [15:0] sample, [20:16] active_voices
   // Configuration writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [19:0] csr_data
);

   psve_pkg::cmd_type    cmd;
   psve_pkg::status_type status;
   logic signed [15:0]   sample;
   logic [4:0]           active_voices;

   psve_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_tvalid && req_tready),
      .req_ready  (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   psve_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_tuser),
      .req_note          (req_tdata[6:0]),
      .req_velocity      (req_tdata[13:7]),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_sample        (sample),
      .rsp_active_voices (active_voices)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {3'd0, active_voices, sample};

endmodule

`default_nettype wire
